// ===== hw/rtl/lppd_pkg.sv =====
// Shared types and constants for the length-prefixed payload deframer.
`timescale 1ns / 1ps

package lppd_pkg;

	localparam int unsigned HEADER_BYTES = 4;
	localparam logic [7:0]  MAX_EXT_LEN  = 8'd255;

	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_DOT = 8'h2E;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_DATA   = 3'd1,
		PH_DOT    = 3'd2,
		PH_EXT    = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_RUN    = 3'd0,
		ST_OK     = 3'd1,
		ST_ZERO   = 3'd2,
		ST_BADEXT = 3'd3,
		ST_TRUNC  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ROLE_HEADER = 2'd0,
		ROLE_DATA   = 2'd1,
		ROLE_EXT    = 2'd2,
		ROLE_IGNORE = 2'd3
	} role_t;

	// One result item as it leaves the parser
	typedef struct packed {
		logic [7:0]  out_byte;
		role_t       byte_role;
		status_t     status;
		logic [31:0] declared_size;
		logic [32:0] dot_offset;
		logic [7:0]  ext_len;
	} result_t;

	// Letters, digits and the dot are legal extension characters
	function automatic logic is_ext_char(input logic [7:0] c);
		is_ext_char = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A) || (c == CHAR_DOT);
	endfunction

endpackage

// ===== hw/rtl/length_prefixed_payload_deframer.sv =====
// Length-prefixed payload deframer: input register, parser and result register.
// A byte passes from the input register through the parser into the result register; a stall can hold it in either.
// Throughput: one byte per cycle; a byte advances whenever the result register is free.
// Reset: arst_n empties both registers and puts the parser in the header phase.
// The final byte of a payload also returns the parser to the header phase.
`timescale 1ns / 1ps

module length_prefixed_payload_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [1:0]  byte_role,
	output logic [2:0]  status,
	output logic [31:0] declared_size,
	output logic [32:0] dot_offset,
	output logic [7:0]  ext_len
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              s2_ready;
	logic              advance;
	lppd_pkg::result_t step_res;
	lppd_pkg::result_t res_out;

	// Input register moves into the parser when the result register can take it
	assign advance  = valid_s1 && s2_ready;
	assign in_ready = !valid_s1 || s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	lppd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.result    (step_res)
	);

	lppd_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_ready (s2_ready),
		.load_data  (step_res),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (res_out)
	);

	assign out_byte      = res_out.out_byte;
	assign byte_role     = res_out.byte_role;
	assign status        = res_out.status;
	assign declared_size = res_out.declared_size;
	assign dot_offset    = res_out.dot_offset;
	assign ext_len       = res_out.ext_len;

endmodule

// ===== hw/rtl/lppd_parser.sv =====
// Parser state and per-byte decode for the deframer.
`timescale 1ns / 1ps

module lppd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output lppd_pkg::result_t   result
);

	lppd_pkg::phase_t  phase_q, phase_n;
	logic [1:0]        hdr_cnt_q, hdr_cnt_n;
	logic [31:0]       size_q, size_n;
	logic [31:0]       remain_q, remain_n;
	logic [7:0]        ext_cnt_q, ext_cnt_n;
	lppd_pkg::status_t fstat_q, fstat_n;
	lppd_pkg::role_t   role;

	// Next state and byte role
	always_comb begin
		phase_n   = phase_q;
		hdr_cnt_n = hdr_cnt_q;
		size_n    = size_q;
		remain_n  = remain_q;
		ext_cnt_n = ext_cnt_q;
		fstat_n   = fstat_q;
		role      = lppd_pkg::ROLE_IGNORE;
		unique case (phase_q)
			lppd_pkg::PH_HEADER: begin
				role   = lppd_pkg::ROLE_HEADER;
				size_n = {size_q[23:0], data_byte};
				if (hdr_cnt_q == 2'(lppd_pkg::HEADER_BYTES - 1)) begin
					hdr_cnt_n = '0;
					if (size_n == '0) begin
						fstat_n = lppd_pkg::ST_ZERO;
						phase_n = lppd_pkg::PH_DONE;
					end else begin
						remain_n = size_n;
						phase_n  = lppd_pkg::PH_DATA;
					end
				end else begin
					hdr_cnt_n = hdr_cnt_q + 2'd1;
				end
			end
			lppd_pkg::PH_DATA: begin
				role     = lppd_pkg::ROLE_DATA;
				remain_n = remain_q - 32'd1;
				if (remain_q == 32'd1) begin
					phase_n = lppd_pkg::PH_DOT;
				end
			end
			lppd_pkg::PH_DOT: begin
				role = (data_byte == lppd_pkg::CHAR_NUL) ? lppd_pkg::ROLE_IGNORE
					: lppd_pkg::ROLE_EXT;
				if (data_byte == lppd_pkg::CHAR_DOT) begin
					ext_cnt_n = 8'd1;
					phase_n   = lppd_pkg::PH_EXT;
				end else begin
					fstat_n = lppd_pkg::ST_BADEXT;
					phase_n = lppd_pkg::PH_DONE;
				end
			end
			lppd_pkg::PH_EXT: begin
				if (data_byte == lppd_pkg::CHAR_NUL) begin
					role    = lppd_pkg::ROLE_IGNORE;
					fstat_n = (ext_cnt_q <= 8'd1) ? lppd_pkg::ST_BADEXT : lppd_pkg::ST_OK;
					phase_n = lppd_pkg::PH_DONE;
				end else begin
					role = lppd_pkg::ROLE_EXT;
					if (!lppd_pkg::is_ext_char(data_byte) ||
						ext_cnt_q >= lppd_pkg::MAX_EXT_LEN) begin
						fstat_n = lppd_pkg::ST_BADEXT;
						phase_n = lppd_pkg::PH_DONE;
					end else begin
						ext_cnt_n = ext_cnt_q + 8'd1;
					end
				end
			end
			default: begin
				role    = lppd_pkg::ROLE_IGNORE;
				phase_n = lppd_pkg::PH_DONE;
			end
		endcase
	end

	// Result fields from the updated state
	always_comb begin
		result.out_byte      = data_byte;
		result.byte_role     = role;
		result.status        = (last_byte && fstat_n == lppd_pkg::ST_RUN)
			? lppd_pkg::ST_TRUNC : fstat_n;
		result.declared_size = size_n;
		result.dot_offset    = (phase_n == lppd_pkg::PH_HEADER) ? 33'd0
			: ({1'b0, size_n} + 33'(lppd_pkg::HEADER_BYTES));
		result.ext_len       = (result.status == lppd_pkg::ST_OK) ? ext_cnt_n : 8'd0;
	end

	// State update; the last byte of a payload returns to the header phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lppd_pkg::PH_HEADER;
			hdr_cnt_q <= '0;
			size_q    <= '0;
			remain_q  <= '0;
			ext_cnt_q <= '0;
			fstat_q   <= lppd_pkg::ST_RUN;
		end else if (advance) begin
			if (last_byte) begin
				phase_q   <= lppd_pkg::PH_HEADER;
				hdr_cnt_q <= '0;
				size_q    <= '0;
				remain_q  <= '0;
				ext_cnt_q <= '0;
				fstat_q   <= lppd_pkg::ST_RUN;
			end else begin
				phase_q   <= phase_n;
				hdr_cnt_q <= hdr_cnt_n;
				size_q    <= size_n;
				remain_q  <= remain_n;
				ext_cnt_q <= ext_cnt_n;
				fstat_q   <= fstat_n;
			end
		end
	end

endmodule

// ===== hw/rtl/lppd_out_stage.sv =====
// Result register with valid/ready handshake toward the consumer.
`timescale 1ns / 1ps

module lppd_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	output logic              load_ready,
	input  lppd_pkg::result_t load_data,
	output logic              out_valid,
	input  logic              out_ready,
	output lppd_pkg::result_t out_data
);

	logic              valid_s2;
	lppd_pkg::result_t data_s2;

	// Register is free when empty or when its transfer completes this cycle
	assign load_ready = !valid_s2 || out_ready;
	assign out_valid  = valid_s2;
	assign out_data   = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_ready) begin
			valid_s2 <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			data_s2 <= load_data;
		end
	end

endmodule

// ===== tb/tb_length_prefixed_payload_deframer.sv =====
// Self-checking testbench for the length-prefixed payload deframer.
`timescale 1ns / 1ps

module tb_length_prefixed_payload_deframer;

	localparam int unsigned ITEM_TARGET = 1950;
	localparam int unsigned CYCLE_LIMIT = 2000000;

	typedef enum int {
		FR_GOOD,
		FR_ZERO,
		FR_BAD_DOT,
		FR_BAD_CHAR,
		FR_EMPTY_EXT,
		FR_LONG_EXT,
		FR_TRUNC,
		FR_HUGE
	} frame_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic [1:0]  byte_role;
	logic [2:0]  status;
	logic [31:0] declared_size;
	logic [32:0] dot_offset;
	logic [7:0]  ext_len;

	int unsigned       cycle_count = 0;
	int unsigned       sent = 0;
	int unsigned       payloads = 0;
	int unsigned       in_idle_pct = 0;
	int unsigned       out_idle_pct = 0;
	int unsigned       out_hold = 0;
	logic [7:0]        frame_q[$];
	lppd_pkg::result_t seen;

	length_prefixed_payload_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.byte_role     (byte_role),
		.status        (status),
		.declared_size (declared_size),
		.dot_offset    (dot_offset),
		.ext_len       (ext_len)
	);

	// Letters, digits and the dot may follow the extension dot
	function automatic logic ext_legal(input logic [7:0] c);
		ext_legal = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
			(c >= "a" && c <= "z") || (c == lppd_pkg::CHAR_DOT);
	endfunction

	// Parser prediction plus the queue of results still owed by the block
	class deframe_sb_t;
		lppd_pkg::phase_t  ph;
		logic [1:0]        hdr_cnt;
		logic [31:0]       size_reg;
		logic [31:0]       remaining;
		logic [7:0]        ext_cnt;
		lppd_pkg::status_t fin;
		lppd_pkg::result_t owed[$];
		int unsigned errors, checked;
		int unsigned ends_ok, ends_zero, ends_bad, ends_trunc;

		function void clear();
			ph = lppd_pkg::PH_HEADER;
			hdr_cnt = '0;
			size_reg = '0;
			remaining = '0;
			ext_cnt = '0;
			fin = lppd_pkg::ST_RUN;
		endfunction

		function new();
			clear();
			errors = 0;
			checked = 0;
			ends_ok = 0;
			ends_zero = 0;
			ends_bad = 0;
			ends_trunc = 0;
		endfunction

		function void settle(input lppd_pkg::status_t s);
			fin = s;
			ph = lppd_pkg::PH_DONE;
		endfunction

		// Advance the parser by one accepted byte and queue its result
		function void note_byte(input logic [7:0] b, input logic lst);
			lppd_pkg::result_t exp_r;
			lppd_pkg::role_t   role;
			lppd_pkg::status_t st;
			role = lppd_pkg::ROLE_IGNORE;
			case (ph)
				lppd_pkg::PH_HEADER: begin
					role = lppd_pkg::ROLE_HEADER;
					size_reg = {size_reg[23:0], b};
					if (hdr_cnt == lppd_pkg::HEADER_BYTES - 1) begin
						hdr_cnt = '0;
						if (size_reg == 32'd0) begin
							settle(lppd_pkg::ST_ZERO);
						end else begin
							remaining = size_reg;
							ph = lppd_pkg::PH_DATA;
						end
					end else begin
						hdr_cnt = hdr_cnt + 2'd1;
					end
				end
				lppd_pkg::PH_DATA: begin
					role = lppd_pkg::ROLE_DATA;
					remaining = remaining - 32'd1;
					if (remaining == 32'd0)
						ph = lppd_pkg::PH_DOT;
				end
				lppd_pkg::PH_DOT: begin
					role = (b == lppd_pkg::CHAR_NUL) ? lppd_pkg::ROLE_IGNORE
						: lppd_pkg::ROLE_EXT;
					if (b == lppd_pkg::CHAR_DOT) begin
						ext_cnt = 8'd1;
						ph = lppd_pkg::PH_EXT;
					end else begin
						settle(lppd_pkg::ST_BADEXT);
					end
				end
				lppd_pkg::PH_EXT: begin
					if (b == lppd_pkg::CHAR_NUL) begin
						role = lppd_pkg::ROLE_IGNORE;
						settle((ext_cnt <= 8'd1) ? lppd_pkg::ST_BADEXT : lppd_pkg::ST_OK);
					end else begin
						role = lppd_pkg::ROLE_EXT;
						if (!ext_legal(b) || ext_cnt >= lppd_pkg::MAX_EXT_LEN)
							settle(lppd_pkg::ST_BADEXT);
						else
							ext_cnt = ext_cnt + 8'd1;
					end
				end
				default: role = lppd_pkg::ROLE_IGNORE;
			endcase

			st = fin;
			if (lst && st == lppd_pkg::ST_RUN)
				st = lppd_pkg::ST_TRUNC;

			exp_r.out_byte = b;
			exp_r.byte_role = role;
			exp_r.status = st;
			exp_r.declared_size = size_reg;
			exp_r.dot_offset = (ph == lppd_pkg::PH_HEADER) ? 33'd0 :
				{1'b0, size_reg} + 33'(lppd_pkg::HEADER_BYTES);
			exp_r.ext_len = (st == lppd_pkg::ST_OK) ? ext_cnt : 8'd0;
			owed.push_back(exp_r);

			// payload ends: tally the outcome and go back to the header phase
			if (lst) begin
				case (st)
					lppd_pkg::ST_OK:     ends_ok++;
					lppd_pkg::ST_ZERO:   ends_zero++;
					lppd_pkg::ST_BADEXT: ends_bad++;
					default:             ends_trunc++;
				endcase
				clear();
			end
		endfunction

		function void match(input string name, input logic [32:0] exp_v,
				input logic [32:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s: expected %0h, got %0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		// Compare one result transfer with the oldest prediction
		function void check_result(input lppd_pkg::result_t got);
			lppd_pkg::result_t exp_r;
			if (owed.size() == 0) begin
				$error("result transfer with nothing outstanding (byte %0h)", got.out_byte);
				errors++;
				return;
			end
			exp_r = owed.pop_front();
			checked++;
			match("out_byte", 33'(exp_r.out_byte), 33'(got.out_byte));
			match("byte_role", 33'(exp_r.byte_role), 33'(got.byte_role));
			match("status", 33'(exp_r.status), 33'(got.status));
			match("declared_size", 33'(exp_r.declared_size), 33'(got.declared_size));
			match("dot_offset", exp_r.dot_offset, got.dot_offset);
			match("ext_len", 33'(exp_r.ext_len), 33'(got.ext_len));
		endfunction
	endclass

	deframe_sb_t board = new();

	// Clock and cycle counter
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Mostly no gap, some short ones, a few long
	function automatic int unsigned pick_gap(input int unsigned pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	// Result side backpressure
	always @(posedge clk) begin
		if (out_hold != 0) begin
			out_ready <= 1'b0;
			out_hold = out_hold - 1;
		end else begin
			out_ready <= 1'b1;
			out_hold = pick_gap(out_idle_pct);
		end
	end

	// Values are stable at the falling edge and transfer at the next rising edge
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen.out_byte = out_byte;
			seen.byte_role = lppd_pkg::role_t'(byte_role);
			seen.status = lppd_pkg::status_t'(status);
			seen.declared_size = declared_size;
			seen.dot_offset = dot_offset;
			seen.ext_len = ext_len;
			board.check_result(seen);
		end
	end

	// Offer one byte and hold it until the transfer
	task automatic push_byte(input logic [7:0] d, input logic lst);
		int unsigned gap;
		logic        fired;
		gap = pick_gap(in_idle_pct);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		last_byte <= lst;
		do begin
			@(negedge clk);
			fired = in_ready;
			@(posedge clk);
		end while (!fired);
		board.note_byte(d, lst);
		sent++;
	endtask

	task automatic send_frame();
		if ($urandom_range(3) == 0) begin
			in_idle_pct = 0;
			out_idle_pct = 0;
		end else begin
			in_idle_pct = $urandom_range(10, 50);
			out_idle_pct = $urandom_range(10, 50);
		end
		for (int i = 0; i < frame_q.size(); i++)
			push_byte(frame_q[i], i == frame_q.size() - 1);
		payloads++;
		frame_q.delete();
	endtask

	task automatic put_size(input logic [31:0] sz);
		frame_q.push_back(sz[31:24]);
		frame_q.push_back(sz[23:16]);
		frame_q.push_back(sz[15:8]);
		frame_q.push_back(sz[7:0]);
	endtask

	task automatic put_ext_chars(input int unsigned n);
		int unsigned k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 62);
			if (k < 10)
				frame_q.push_back(8'("0" + k));
			else if (k < 36)
				frame_q.push_back(8'("A" + k - 10));
			else if (k < 62)
				frame_q.push_back(8'("a" + k - 36));
			else
				frame_q.push_back(lppd_pkg::CHAR_DOT);
		end
	endtask

	task automatic put_random(input int unsigned n);
		for (int i = 0; i < n; i++)
			frame_q.push_back(8'($urandom_range(0, 255)));
	endtask

	// Any nonzero byte that is not a legal extension character
	function automatic logic [7:0] pick_bad_char();
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255)); while (ext_legal(c));
		return c;
	endfunction

	function automatic frame_kind_t pick_kind();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 40) return FR_GOOD;
		if (r < 55) return FR_TRUNC;
		if (r < 65) return FR_BAD_DOT;
		if (r < 75) return FR_BAD_CHAR;
		if (r < 83) return FR_EMPTY_EXT;
		if (r < 91) return FR_ZERO;
		if (r < 98) return FR_HUGE;
		return FR_LONG_EXT;
	endfunction

	// Assemble one payload of the given kind in frame_q
	task automatic build_frame(input frame_kind_t kind);
		int unsigned n, cut;
		logic [31:0] sz;
		logic [7:0]  c;
		n = ($urandom_range(9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 6);
		case (kind)
			FR_ZERO: begin
				put_size(32'd0);
				put_random($urandom_range(0, 3));
			end
			FR_HUGE: begin
				sz = $urandom;
				if (sz == 32'd0)
					sz = 32'hFFFF_FFFF;
				put_size(sz);
				put_random($urandom_range(0, 5));
				cut = $urandom_range(1, frame_q.size());
				while (frame_q.size() > cut)
					void'(frame_q.pop_back());
			end
			default: begin
				put_size(n);
				put_random(n);
				case (kind)
					FR_BAD_DOT: begin
						if ($urandom_range(3) == 0) begin
							frame_q.push_back(lppd_pkg::CHAR_NUL);
						end else begin
							do c = 8'($urandom_range(0, 255)); while (c == lppd_pkg::CHAR_DOT);
							frame_q.push_back(c);
						end
					end
					FR_BAD_CHAR: begin
						frame_q.push_back(lppd_pkg::CHAR_DOT);
						put_ext_chars($urandom_range(0, 3));
						frame_q.push_back(pick_bad_char());
					end
					FR_EMPTY_EXT: begin
						frame_q.push_back(lppd_pkg::CHAR_DOT);
						frame_q.push_back(lppd_pkg::CHAR_NUL);
					end
					FR_LONG_EXT: begin
						// dot plus 254 characters is the longest legal extension
						frame_q.push_back(lppd_pkg::CHAR_DOT);
						put_ext_chars(lppd_pkg::MAX_EXT_LEN - 1);
						if ($urandom_range(1) == 0)
							frame_q.push_back(lppd_pkg::CHAR_NUL);
						else
							put_ext_chars(1);
					end
					default: begin
						frame_q.push_back(lppd_pkg::CHAR_DOT);
						if ($urandom_range(14) == 0)
							put_ext_chars($urandom_range(100, 254));
						else
							put_ext_chars($urandom_range(1, 6));
						frame_q.push_back(lppd_pkg::CHAR_NUL);
					end
				endcase
				if (kind == FR_TRUNC) begin
					cut = $urandom_range(1, frame_q.size() - 1);
					while (frame_q.size() > cut)
						void'(frame_q.pop_back());
				end
			end
		endcase
		// bytes after a settled status are ignored until the last one
		if (kind != FR_TRUNC && kind != FR_HUGE && $urandom_range(2) == 0)
			put_random($urandom_range(1, 3));
	endtask

	// Stop the run if the block stops making progress
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$error("no completion within %0d cycles", CYCLE_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// Main sequence
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// shortest legal payload: one data byte, one extension letter
		put_size(32'd1);
		frame_q.push_back(8'hFF);
		frame_q.push_back(lppd_pkg::CHAR_DOT);
		frame_q.push_back("z");
		frame_q.push_back(lppd_pkg::CHAR_NUL);
		send_frame();
		// zero size, ending right on the last header byte
		put_size(32'd0);
		send_frame();
		// dot followed directly by the terminator
		put_size(32'd1);
		frame_q.push_back(8'h00);
		frame_q.push_back(lppd_pkg::CHAR_DOT);
		frame_q.push_back(lppd_pkg::CHAR_NUL);
		send_frame();
		// terminator where the dot belongs
		put_size(32'd1);
		frame_q.push_back(8'hA5);
		frame_q.push_back(lppd_pkg::CHAR_NUL);
		send_frame();

		// random payloads, about two in five of them well formed
		while (sent < ITEM_TARGET) begin
			build_frame(pick_kind());
			send_frame();
		end
		in_valid <= 1'b0;

		while (board.owed.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		$display("Sent %0d bytes in %0d payloads, %0d results checked.",
			sent, payloads, board.checked);
		$display("Endings: ok %0d, zero size %0d, bad extension %0d, truncated %0d.",
			board.ends_ok, board.ends_zero, board.ends_bad, board.ends_trunc);
		if (board.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/lppd_pkg.sv
hw/rtl/lppd_parser.sv
hw/rtl/lppd_out_stage.sv
hw/rtl/length_prefixed_payload_deframer.sv
tb/tb_length_prefixed_payload_deframer.sv
